@@ src/oer_pkg.sv @@
// Package for the overwriting entry ring: request codes, store geometry and
// the field widths shared by the ring unit and its entry RAM.
// No dependencies.
package oer_pkg;

  // Geometry of the entry store.
  localparam int unsigned RingDepth = 256;
  localparam int unsigned EntryBits = 32;
  localparam int unsigned SlotW     = $clog2(RingDepth);
  localparam int unsigned CfgW      = 9;
  localparam int unsigned ReqW      = 3;

  // Request codes carried in the input tuser field.
  localparam logic [ReqW-1:0] REQ_APPEND     = 3'd0;
  localparam logic [ReqW-1:0] REQ_FLUSH      = 3'd1;
  localparam logic [ReqW-1:0] REQ_FLUSH_TO   = 3'd2;
  localparam logic [ReqW-1:0] REQ_ITER_START = 3'd3;
  localparam logic [ReqW-1:0] REQ_ITER_NEXT  = 3'd4;

endpackage

@@ src/overwriting_entry_ring_unit.sv @@
// Overwriting entry ring: every accepted word yields one result word, passing
// through the request register and entry RAM read, then the result queue; one
// word can be accepted in every cycle while the result queue has room.
// Reset is asynchronous and active low: the ring comes up empty with all
// slots in use and the iterator done. The entry RAM is not cleared.
// Depends on oer_pkg and oer_ram.
module overwriting_entry_ring_unit
  import oer_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: number of slots in use.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entry_data [31:0], target_slot [39:32]
  input  logic [2:0]  s_axis_tuser,  // req_type [2:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data [31:0], read_slot [39:32], oldest_slot [47:40],
  // newest_slot [55:48], is_empty [56], zero fill [63:57]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser   // found [0]
);

  localparam int unsigned QDepth = 3;

  // Status that travels with a result while the RAM read completes.
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] rslot;
    logic [SlotW-1:0] oldest;
    logic [SlotW-1:0] newest;
    logic             empty;
  } meta_t;

  typedef struct packed {
    meta_t                meta;
    logic [EntryBits-1:0] data;
  } res_t;

  // The configuration register is kept as the index of the last slot in use,
  // so that both the wrap test and the flush_to range test are plain compares.
  logic [SlotW-1:0] last_q;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [SlotW-1:0] newest_q, newest_d;
  logic             empty_q, empty_d;
  logic [SlotW-1:0] cur_q, cur_d;
  logic [SlotW-1:0] stop_q, stop_d;
  logic             done_q, done_d;

  logic             s1_valid_q;
  meta_t            s1_meta_q, meta_d;

  res_t             queue_q [QDepth];
  logic [1:0]       wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  logic             accept;
  logic             ram_we, ram_re;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [EntryBits-1:0] ram_rdata;
  logic [SlotW-1:0] dst;
  logic [2:0]       occupancy;
  logic             push, pop;

  logic [ReqW-1:0]      req_type;
  logic [EntryBits-1:0] entry_data;
  logic [SlotW-1:0]     target_slot;

  assign req_type    = s_axis_tuser;
  assign entry_data  = s_axis_tdata[31:0];
  assign target_slot = s_axis_tdata[39:32];

  // Step one slot forward in ring order. A pointer left beyond the slots in
  // use after the register shrank also wraps to slot 0.
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s,
                                                 input logic [SlotW-1:0] last);
    logic [SlotW-1:0] r;
    if (s >= last) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  // Configuration: a zero count acts as one slot, counts above the store
  // depth act as the full store.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= SlotW'(RingDepth - 1);
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        last_q <= '0;
      end else if (cfg_data_i[8]) begin
        last_q <= SlotW'(RingDepth - 1);
      end else begin
        last_q <= cfg_data_i[7:0] - 1'b1;
      end
    end
  end

  // Room is counted over the word in the RAM read stage plus the queue, so the
  // request side never waits on the result side's ready in the same cycle.
  assign occupancy     = {1'b0, cnt_q} + {2'b00, s1_valid_q};
  assign s_axis_tready = (occupancy < 3'(QDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Pointer and iterator update for the accepted request.
  always_comb begin
    oldest_d  = oldest_q;
    newest_d  = newest_q;
    empty_d   = empty_q;
    cur_d     = cur_q;
    stop_d    = stop_q;
    done_d    = done_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = cur_q;
    dst       = '0;
    meta_d    = '0;
    if (accept) begin
      case (req_type)
        REQ_APPEND: begin
          if (empty_q) begin
            dst      = '0;
            oldest_d = '0;
            empty_d  = 1'b0;
          end else begin
            dst = next_slot(newest_q, last_q);
            // Full ring: the new entry lands on the oldest one.
            if (dst == oldest_q) begin
              oldest_d = next_slot(oldest_q, last_q);
            end
          end
          ram_we    = 1'b1;
          ram_waddr = dst;
          newest_d  = dst;
        end
        REQ_FLUSH: begin
          oldest_d = '0;
          newest_d = '0;
          empty_d  = 1'b1;
        end
        REQ_FLUSH_TO: begin
          // Ignored on an empty ring and for a slot that is not in use.
          if (!empty_q && (target_slot <= last_q)) begin
            oldest_d = target_slot;
          end
        end
        REQ_ITER_START: begin
          cur_d  = oldest_q;
          stop_d = newest_q;
          done_d = empty_q;
        end
        REQ_ITER_NEXT: begin
          if (!done_q) begin
            meta_d.found = 1'b1;
            meta_d.rslot = cur_q;
            ram_re       = 1'b1;
            if (cur_q == stop_q) begin
              done_d = 1'b1;
            end else begin
              cur_d = next_slot(cur_q, last_q);
            end
          end
        end
        default: begin
        end
      endcase
    end
    meta_d.oldest = oldest_d;
    meta_d.newest = newest_d;
    meta_d.empty  = empty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      newest_q   <= '0;
      empty_q    <= 1'b1;
      cur_q      <= '0;
      stop_q     <= '0;
      done_q     <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      oldest_q   <= oldest_d;
      newest_q   <= newest_d;
      empty_q    <= empty_d;
      cur_q      <= cur_d;
      stop_q     <= stop_d;
      done_q     <= done_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta_d;
    end
  end

  // Entry store. A write and a read never fall in the same cycle, since each
  // request does at most one of them; a read in the cycle after an append
  // sees the appended entry.
  oer_ram #(
    .Width(EntryBits),
    .Depth(RingDepth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(entry_data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result queue. The word leaving the RAM read stage always finds room here
  // because the request side was held back by the occupancy count.
  assign push = s1_valid_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q].meta <= s1_meta_q;
      queue_q[wr_ptr_q].data <= s1_meta_q.found ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'(QDepth - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(QDepth - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = queue_q[rd_ptr_q].meta.found;
  assign m_axis_tdata  = {7'b0,
                          queue_q[rd_ptr_q].meta.empty,
                          queue_q[rd_ptr_q].meta.newest,
                          queue_q[rd_ptr_q].meta.oldest,
                          queue_q[rd_ptr_q].meta.rslot,
                          queue_q[rd_ptr_q].data};

endmodule

@@ src/oer_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. Standalone, no package dependency.
module oer_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_overwriting_entry_ring_unit.sv @@
// Self-checking testbench for overwriting_entry_ring_unit: directed and random request words,
// each checked against a cycle-free ring predictor held in this file.
// Depends on oer_pkg and the ring unit RTL (with its entry RAM).
module tb_overwriting_entry_ring_unit
  import oer_pkg::*;
();

  // Request codes 5 to 7 are not operations; the block only reports its status for them.
  localparam logic [ReqW-1:0] REQ_NOP_FIRST = 3'd5;
  localparam logic [ReqW-1:0] REQ_NOP_LAST  = 3'd7;

  // Pipeline allowance for the block, which registers each request and then queues its result.
  localparam int ReplyLatency = 2;
  localparam int MaxReports   = 10;

  // One result word as it appears on {m_axis_tdata, m_axis_tuser}, highest bits first.
  typedef struct packed {
    logic [6:0]       pad;
    logic             empty;
    logic [SlotW-1:0] newest;
    logic [SlotW-1:0] oldest;
    logic [SlotW-1:0] rslot;
    logic [31:0]      rdata;
    logic             found;
  } ring_reply_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  overwriting_entry_ring_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Predicted ring state. Pointers are kept as plain integers; the store mirrors every
  // append so that iterator reads can be predicted, and entry_written marks the slots
  // that hold data, since the RAM comes up with unknown contents.
  logic [31:0]  entry_copy    [RingDepth];
  bit           entry_written [RingDepth];
  int unsigned  ring_oldest   = 0;
  int unsigned  ring_newest   = 0;
  bit           ring_empty    = 1'b1;
  int unsigned  walk_cursor   = 0;
  int unsigned  walk_stop     = 0;
  bit           walk_done     = 1'b1;
  logic [8:0]   slot_count    = 9'(RingDepth);

  ring_reply_t  pending_replies[$];
  int           mismatches    = 0;

  // Idle behavior of both sides, in percent of cycles, and the receiver hold-off.
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  int           hold_left     = 0;

  // Number of slots actually used: zero acts as one, anything above the depth as the depth.
  function automatic int unsigned slot_span();
    if (slot_count == 9'd0) return 1;
    if (slot_count > 9'(RingDepth)) return RingDepth;
    return 32'(slot_count);
  endfunction

  // Stepping forward from the last slot in use, or from a pointer left beyond it after
  // the slot count shrank, wraps to slot 0.
  function automatic int unsigned step_slot(input int unsigned s);
    if (s + 1 >= slot_span()) return 0;
    return s + 1;
  endfunction

  // Applies one accepted request to the predicted state and returns the result word.
  function automatic ring_reply_t advance_ring(input logic [ReqW-1:0] code,
                                               input logic [31:0] data,
                                               input logic [SlotW-1:0] target);
    ring_reply_t r;
    int unsigned dst;
    r = '0;
    case (code)
      REQ_APPEND: begin
        if (ring_empty) begin
          dst = 0;
          ring_oldest = 0;
          ring_empty = 1'b0;
        end else begin
          dst = step_slot(ring_newest);
          // A full ring loses its oldest entry.
          if (dst == ring_oldest) ring_oldest = step_slot(ring_oldest);
        end
        entry_copy[dst] = data;
        entry_written[dst] = 1'b1;
        ring_newest = dst;
      end
      REQ_FLUSH: begin
        ring_oldest = 0;
        ring_newest = 0;
        ring_empty = 1'b1;
      end
      REQ_FLUSH_TO: begin
        // Ignored on an empty ring or for a slot outside the slots in use.
        if (!ring_empty && target < slot_span()) ring_oldest = 32'(target);
      end
      REQ_ITER_START: begin
        walk_cursor = ring_oldest;
        walk_stop = ring_newest;
        walk_done = ring_empty;
      end
      REQ_ITER_NEXT: begin
        if (!walk_done) begin
          r.found = 1'b1;
          r.rdata = entry_copy[walk_cursor];
          r.rslot = walk_cursor[SlotW-1:0];
          if (walk_cursor == walk_stop) walk_done = 1'b1;
          else walk_cursor = step_slot(walk_cursor);
        end
      end
      default: ;
    endcase
    r.oldest = ring_oldest[SlotW-1:0];
    r.newest = ring_newest[SlotW-1:0];
    r.empty = ring_empty;
    return r;
  endfunction

  function automatic logic [31:0] random_entry();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  // Any slot number the target field can carry.
  function automatic logic [SlotW-1:0] random_slot();
    return SlotW'($urandom_range(255));
  endfunction

  task automatic set_idle_mode(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 6 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 6 : 0;
  endtask

  // Offers one request word and waits for its acceptance; the expectation is formed at
  // the accepting edge. An iterator step that would land on a slot that was never
  // written is sent as an append instead, since that slot has no defined contents.
  task automatic send_word(input logic [ReqW-1:0] code, input logic [31:0] data,
                           input logic [SlotW-1:0] target);
    logic [ReqW-1:0] req;
    req = code;
    if (req == REQ_ITER_NEXT && !walk_done && !entry_written[walk_cursor]) req = REQ_APPEND;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {target, data};
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(advance_ring(req, data, target));
  endtask

  // Stops offering requests and waits until every expected result has come back,
  // plus the pipeline latency, so that the block is idle afterwards.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (ReplyLatency + 4) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [8:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Fresh ring: the iterator is done, flush_to has nothing to act on, and a code
  // outside the defined operations only reports the status.
  task automatic test_empty_ring();
    send_word(REQ_ITER_NEXT, $urandom, random_slot());
    send_word(REQ_FLUSH_TO, $urandom, 8'd0);
    send_word(REQ_NOP_LAST, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // Extreme entry values, then a walk that runs one step past the newest entry.
  task automatic test_append_walk();
    send_word(REQ_APPEND, 32'h0, 8'h0);
    send_word(REQ_APPEND, 32'hFFFF_FFFF, 8'hFF);
    send_word(REQ_ITER_START, $urandom, 8'h0);
    repeat (3) send_word(REQ_ITER_NEXT, $urandom, random_slot());
  endtask

  // Flush_to past the newest entry is taken in plain ring order; a second flush_to
  // brings the oldest back onto a written slot before walking.
  task automatic test_flush_to();
    send_word(REQ_FLUSH_TO, $urandom, 8'hFF);
    send_word(REQ_FLUSH_TO, $urandom, 8'd1);
    send_word(REQ_ITER_START, $urandom, 8'h0);
    send_word(REQ_ITER_NEXT, $urandom, 8'h0);
  endtask

  // A flush in the middle of a walk leaves the iterator running on the old range.
  task automatic test_flush_mid_walk();
    send_word(REQ_APPEND, random_entry(), random_slot());
    send_word(REQ_ITER_START, $urandom, 8'h0);
    send_word(REQ_ITER_NEXT, $urandom, 8'h0);
    send_word(REQ_FLUSH, $urandom, random_slot());
    send_word(REQ_ITER_NEXT, $urandom, 8'h0);
  endtask

  // Two slots: the third append overwrites the oldest entry, and flush_to at a slot
  // outside the slots in use is ignored.
  task automatic test_small_ring();
    write_slot_count(9'd2);
    repeat (3) send_word(REQ_APPEND, $urandom, random_slot());
    send_word(REQ_FLUSH_TO, $urandom, 8'd2);
    send_word(REQ_ITER_START, $urandom, 8'h0);
    repeat (2) send_word(REQ_ITER_NEXT, $urandom, 8'h0);
  endtask

  // A slot count of zero acts as one; the oldest pointer is left beyond the single
  // slot in use, and the walk from it wraps to slot 0.
  task automatic test_slot_count_zero();
    write_slot_count(9'd0);
    send_word(REQ_APPEND, $urandom, random_slot());
    send_word(REQ_ITER_START, $urandom, 8'h0);
    repeat (2) send_word(REQ_ITER_NEXT, $urandom, 8'h0);
  endtask

  // The receiver holds off for a long stretch while appends keep coming back to back,
  // so the result path fills up and the block must stall its input.
  task automatic test_receiver_hold();
    write_slot_count(9'(RingDepth));
    set_idle_mode(IDLE_NONE);
    hold_left = 150;
    repeat (60) send_word(REQ_APPEND, random_entry(), random_slot());
  endtask

  // Mostly well-formed traffic: appends, and iterator starts each followed by a run of
  // steps, with flushes, flush_to requests and undefined codes mixed in. Undefined
  // codes do not count toward the item total.
  task automatic run_mixed_traffic(input int item_total);
    int sent;
    int pick;
    int steps;
    logic [SlotW-1:0] target;
    sent = 0;
    while (sent < item_total) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_word(REQ_APPEND, random_entry(), random_slot());
        sent++;
      end else if (pick < 62) begin
        steps = $urandom_range(1, 20);
        send_word(REQ_ITER_START, $urandom, random_slot());
        repeat (steps) send_word(REQ_ITER_NEXT, $urandom, random_slot());
        sent += steps + 1;
      end else if (pick < 72) begin
        // Mostly slots in use, sometimes any slot number.
        if ($urandom_range(3) != 0) target = SlotW'($urandom_range(slot_span() - 1));
        else target = random_slot();
        send_word(REQ_FLUSH_TO, $urandom, target);
        sent++;
      end else if (pick < 76) begin
        send_word(REQ_FLUSH, $urandom, random_slot());
        sent++;
      end else if (pick < 84) begin
        send_word(REQ_ITER_NEXT, $urandom, random_slot());
        sent++;
      end else if (pick < 89) begin
        send_word(ReqW'($urandom_range(REQ_NOP_FIRST, REQ_NOP_LAST)), $urandom,
                  random_slot());
      end else begin
        send_word(REQ_APPEND, $urandom, random_slot());
        sent++;
      end
    end
  endtask

  // Phases with different slot counts, including both extremes, zero, a value above the
  // depth and a shrink that strands the pointers beyond the slots in use.
  task automatic test_random_traffic();
    logic [8:0] slot_plan [8];
    slot_plan = '{9'd256, 9'd5, 9'd511, 9'd1, 9'd0, 9'd0, 9'd256, 9'd3};
    slot_plan[4] = 9'($urandom_range(2, 40));
    for (int phase = 0; phase < 8; phase++) begin
      write_slot_count(slot_plan[phase]);
      set_idle_mode(idle_mode_t'(phase % 4));
      run_mixed_traffic(85);
    end
  endtask

  // Receiver: a requested hold-off takes precedence, otherwise it stalls at random.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted result word is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_replies
    ring_reply_t got;
    ring_reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected result word %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result mismatch: expected found %b data %h slot %0d oldest %0d",
                     want.found, want.rdata, want.rslot, want.oldest);
            $display("                 expected newest %0d empty %b pad %h",
                     want.newest, want.empty, want.pad);
            $display("                 actual   found %b data %h slot %0d oldest %0d",
                     got.found, got.rdata, got.rslot, got.oldest);
            $display("                 actual   newest %0d empty %b pad %h",
                     got.newest, got.empty, got.pad);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idle_mode(IDLE_NONE);
    test_empty_ring();
    test_append_walk();
    test_flush_to();
    test_flush_mid_walk();
    test_small_ring();
    test_slot_count_zero();
    test_receiver_hold();
    test_random_traffic();

    drain_results();
    mismatches += pending_replies.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/oer_pkg.sv
src/oer_ram.sv
src/overwriting_entry_ring_unit.sv
tb/tb_overwriting_entry_ring_unit.sv
